FILE: design/address_range_lookup_defines.svh
// Assertion macros shared by the address range lookup RTL.
`ifndef ADDRESS_RANGE_LOOKUP_DEFINES_SVH
`define ADDRESS_RANGE_LOOKUP_DEFINES_SVH

`ifndef SYNTHESIS

// Checked on every rising clock edge outside reset.
`define ARL_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ARL_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`else

`define ARL_ASSERT(lbl, prop, msg)

`define ARL_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: design/arl_pkg.sv
// Package with the types and constants of the address range lookup.
package arl_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 65536;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = IDX_W + 1;

   // Field widths.
   localparam int ADDR_W      = 32;
   localparam int CODE_W      = 16;
   localparam int FLAG_W      = 8;
   localparam int SLOT_W      = 16;

   // Configuration port.
   localparam int COUNT_REG_W = 17;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = COUNT_REG_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRY_COUNT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNKNOWN_FLAG = 2'd1;

   localparam logic [FLAG_W-1:0] UNKNOWN_FLAG_RESET = 8'd53;

   // Transaction operation codes.
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // One stored table entry.
   typedef struct packed {
      logic [ADDR_W-1:0] range_start;
      logic [ADDR_W-1:0] range_end;
      logic [CODE_W-1:0] region;
      logic [CODE_W-1:0] territory;
      logic [FLAG_W-1:0] flag;
   } arl_entry_type;

   // Read request from the search sequencer to the table memory.
   typedef struct packed {
      logic             enable;
      logic [IDX_W-1:0] addr;
   } arl_rd_req_type;

   // One lookup result.
   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] match_index;
      logic [CODE_W-1:0] region;
      logic [CODE_W-1:0] territory;
      logic [FLAG_W-1:0] flag;
   } arl_result_type;

endpackage

FILE: design/address_range_lookup.sv
// Top level of the address range lookup: registers, table memory and result stage.
//
//   Channel  Direction  Handshake                  Contents
//   req_     in         req_valid / req_stall      write of one entry, or address lookup
//   rsp_     out        rsp_valid / rsp_stall      one result per lookup, none per write
//   csr_     in         csr_write_enable           entry_count and unknown_flag
//
// A write transaction is stored in the cycle it is accepted and the next transaction can
// follow right away. Once a lookup is accepted, req_stall stays high through the setup, P
// probes and the wait for the result to be taken, where P is 0 for an empty table, at most
// floor(log2(n)) + 1 for n entries, so 17 for a full table of 65536. The single read port
// of the table memory, with its registered read, sets the pace of one probe per cycle.
// Reset is synchronous and clears the control state and the configuration registers; the
// table itself is not cleared and holds whatever was written.
// A finished result waits in an output register while rsp_stall is high, so new transactions
// are still taken; a second result then waits in the sequencer until the register drains.
`include "address_range_lookup_defines.svh"

module address_range_lookup (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_operation,
   input  logic [15:0]                        req_entry_index,
   input  logic [31:0]                        req_range_start,
   input  logic [31:0]                        req_range_end,
   input  logic [15:0]                        req_region_in,
   input  logic [15:0]                        req_territory_in,
   input  logic [7:0]                         req_flag_in,
   input  logic [31:0]                        req_address,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_found,
   output logic [15:0]                        rsp_match_index,
   output logic [15:0]                        rsp_region_out,
   output logic [15:0]                        rsp_territory_out,
   output logic [7:0]                         rsp_flag_out,

   input  logic                               csr_write_enable,
   input  logic [arl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [arl_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   import arl_pkg::*;

   // Configuration registers.
   logic [COUNT_REG_W-1:0] entry_count_ff, entry_count_in;
   logic [FLAG_W-1:0]      unknown_flag_ff, unknown_flag_in;

   // Output stage.
   logic                   rsp_valid_ff, rsp_valid_in;
   arl_result_type         rsp_data_ff, rsp_data_in;

   logic                   busy;
   logic                   req_accept;
   logic                   lookup_start;
   logic                   slot_in_range;
   logic                   ram_we;
   logic [IDX_W-1:0]       ram_wr_addr;
   arl_entry_type          ram_wr_data;
   arl_rd_req_type         rd_req;
   arl_entry_type          rd_entry;
   logic [COUNT_W-1:0]     search_count;
   logic                   res_valid;
   logic                   res_take;
   arl_result_type         result;

   // Configuration writes. Indexes beyond the two registers are ignored.
   always_comb begin
      entry_count_in  = entry_count_ff;
      unknown_flag_in = unknown_flag_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ENTRY_COUNT:  entry_count_in  = csr_write_data[COUNT_REG_W-1:0];
            CSR_UNKNOWN_FLAG: unknown_flag_in = csr_write_data[FLAG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff  <= '0;
         unknown_flag_ff <= UNKNOWN_FLAG_RESET;
      end else begin
         entry_count_ff  <= entry_count_in;
         unknown_flag_ff <= unknown_flag_in;
      end
   end

   // A count above the table depth searches the whole table.
   assign search_count = (32'(entry_count_ff) > 32'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH)
                                                                  : COUNT_W'(entry_count_ff);

   // Only one transaction is in the sequencer at a time, which also keeps table writes away
   // from a search in progress.
   assign req_stall    = busy;
   assign req_accept   = req_valid && !req_stall;
   assign lookup_start = req_accept && (req_operation == OP_LOOKUP);

   // Writes to a slot past the end of the table are dropped.
   assign slot_in_range = 32'(req_entry_index) < 32'(TABLE_DEPTH);
   assign ram_we        = req_accept && (req_operation == OP_WRITE) && slot_in_range;
   assign ram_wr_addr   = IDX_W'(req_entry_index);

   always_comb begin
      ram_wr_data.range_start = req_range_start;
      ram_wr_data.range_end   = req_range_end;
      ram_wr_data.region      = req_region_in;
      ram_wr_data.territory   = req_territory_in;
      ram_wr_data.flag        = req_flag_in;
   end

   arl_ram #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH ($bits(arl_entry_type))
   ) u_table (
      .clock     (clock),
      .wr_enable (ram_we),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_enable (rd_req.enable),
      .rd_addr   (rd_req.addr),
      .rd_data   (rd_entry)
   );

   arl_search u_search (
      .clock        (clock),
      .reset        (reset),
      .start        (lookup_start),
      .address      (req_address),
      .entry_count  (search_count),
      .unknown_flag (unknown_flag_ff),
      .rd_req       (rd_req),
      .rd_entry     (rd_entry),
      .busy         (busy),
      .res_valid    (res_valid),
      .result       (result),
      .res_take     (res_take)
   );

   // The result moves into the output register when it is empty or drains this cycle.
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = res_take || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = res_take ? result : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_data_ff.found;
   assign rsp_match_index   = rsp_data_ff.match_index;
   assign rsp_region_out    = rsp_data_ff.region;
   assign rsp_territory_out = rsp_data_ff.territory;
   assign rsp_flag_out      = rsp_data_ff.flag;

   `ARL_ASSERT(a_lookup_goes_busy,
      lookup_start |=> busy,
      "accepted lookup did not start a search")
   `ARL_ASSERT(a_result_held,
      (res_valid && !res_take) |=> res_valid,
      "search result dropped while the output register was full")

endmodule

FILE: design/arl_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
module arl_ram #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 1
) (
   input  logic                     clock,
   input  logic                     wr_enable,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_enable,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_enable) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read is issued.
   always_ff @(posedge clock) begin
      if (rd_enable) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/arl_search.sv
// Binary search sequencer that probes the range table one entry per cycle.
`include "address_range_lookup_defines.svh"

module arl_search (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [arl_pkg::ADDR_W-1:0]     address,
   input  logic [arl_pkg::COUNT_W-1:0]    entry_count,
   input  logic [arl_pkg::FLAG_W-1:0]     unknown_flag,
   output arl_pkg::arl_rd_req_type        rd_req,
   input  arl_pkg::arl_entry_type         rd_entry,
   output logic                           busy,
   output logic                           res_valid,
   output arl_pkg::arl_result_type        result,
   input  logic                           res_take
);

   import arl_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SETUP = 4'b0010,
      S_PROBE = 4'b0100,
      S_DONE  = 4'b1000
   } arl_state_type;

   // Midpoint of the window [lo, hx), rounded down.
   function automatic logic [IDX_W-1:0] probe_point(input logic [COUNT_W-1:0] lo,
                                                    input logic [COUNT_W-1:0] hx);
      logic [COUNT_W-1:0] span;
      span = hx - lo - COUNT_W'(1);
      return IDX_W'(lo + (span >> 1));
   endfunction

   arl_state_type        state_ff, state_in;
   logic [ADDR_W-1:0]    address_ff, address_in;
   logic [COUNT_W-1:0]   low_ff, low_in;
   logic [COUNT_W-1:0]   hix_ff, hix_in;
   logic [IDX_W-1:0]     mid_ff, mid_in;
   logic                 found_ff, found_in;

   logic [COUNT_W-1:0]   mid_ext;
   logic [COUNT_W-1:0]   mid_next;
   logic                 hit;
   logic                 below;
   logic [IDX_W-1:0]     left_mid;
   logic [IDX_W-1:0]     right_mid;
   logic                 left_more;
   logic                 right_more;

   // The next midpoint for either direction is prepared while the probe compares.
   always_comb begin
      mid_ext    = COUNT_W'(mid_ff);
      mid_next   = mid_ext + COUNT_W'(1);
      hit        = (address_ff >= rd_entry.range_start) && (address_ff <= rd_entry.range_end);
      below      = address_ff < rd_entry.range_start;
      left_mid   = probe_point(low_ff, mid_ext);
      right_mid  = probe_point(mid_next, hix_ff);
      left_more  = low_ff < mid_ext;
      right_more = mid_next < hix_ff;
   end

   always_comb begin
      state_in   = state_ff;
      address_in = address_ff;
      low_in     = low_ff;
      hix_in     = hix_ff;
      mid_in     = mid_ff;
      found_in   = found_ff;
      rd_req.enable = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               address_in = address;
               low_in     = '0;
               hix_in     = entry_count;
               found_in   = 1'b0;
               state_in   = S_SETUP;
            end
         end
         S_SETUP: begin
            if (low_ff < hix_ff) begin
               mid_in        = probe_point(low_ff, hix_ff);
               rd_req.enable = 1'b1;
               state_in      = S_PROBE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_PROBE: begin
            if (hit) begin
               found_in = 1'b1;
               state_in = S_DONE;
            end else if (below) begin
               hix_in = mid_ext;
               if (left_more) begin
                  mid_in        = left_mid;
                  rd_req.enable = 1'b1;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               low_in = mid_next;
               if (right_more) begin
                  mid_in        = right_mid;
                  rd_req.enable = 1'b1;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rd_req.addr = mid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      address_ff <= address_in;
      low_ff     <= low_in;
      hix_ff     <= hix_in;
      mid_ff     <= mid_in;
      found_ff   <= found_in;
   end

   // The payload of a hit comes straight from the held read data of the last probe.
   always_comb begin
      if (found_ff) begin
         result.found       = 1'b1;
         result.match_index = SLOT_W'(mid_ff);
         result.region      = rd_entry.region;
         result.territory   = rd_entry.territory;
         result.flag        = rd_entry.flag;
      end else begin
         result.found       = 1'b0;
         result.match_index = '0;
         result.region      = '0;
         result.territory   = '0;
         result.flag        = unknown_flag;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign res_valid = (state_ff == S_DONE);

   `ARL_ASSERT(a_probe_in_window,
      (state_ff == S_PROBE) |-> ((low_ff <= mid_ext) && (mid_ext < hix_ff)),
      "probe index left the search window")
   `ARL_ASSERT(a_read_then_probe,
      rd_req.enable |=> (state_ff == S_PROBE),
      "table read issued without a following probe")

endmodule
